// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RKD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RKD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/rkd_pkg.sv =====
// Package with the shared widths, codes and types of the dedup table.
`default_nettype none

package rkd_pkg;

	localparam int KEY_W = 64;
	localparam int TIME_W = 64;
	localparam int WIN_W = 32;
	localparam int OP_W = 2;

	localparam int DEF_ENTRIES = 64;
	localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd20000;

	// Operation codes of a request beat.
	localparam logic [OP_W-1:0] OP_CHECK_MARK = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// One table word: a key and the stamp of its last mark.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	// Scan control from the sequencer to the compare stage.
	typedef struct packed {
		logic start;
		logic issue;
	} scan_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/rkd_intf.sv =====
// Request and response channel interfaces of the dedup table.
`default_nettype none

interface rkd_req_if import rkd_pkg::*; ();
	logic valid;
	logic ready;
	logic [OP_W-1:0] operation;
	logic [KEY_W-1:0] key;
	logic [TIME_W-1:0] now;

	modport source(output valid, output operation, output key, output now, input ready);
	modport sink(input valid, input operation, input key, input now, output ready);
endinterface

interface rkd_rsp_if;
	logic valid;
	logic ready;
	logic was_recent;
	logic marked;

	modport source(output valid, output was_recent, output marked, input ready);
	modport sink(input valid, input was_recent, input marked, output ready);
endinterface

`default_nettype wire

// ===== sv/recent_key_dedup_table.sv =====
// Top level of the time-window dedup table: sequencer, config and result register.
//
// Requests arrive on req (operation, key, now), one result per request leaves on
// rsp (was_recent, marked); both are valid/ready channels and a beat moves when
// valid and ready are high at a rising edge. cfg_we with cfg_wdata writes the
// 32-bit window register; write it only while the block is idle.
// The table lives in one memory of ENTRIES words of key and stamp. A check-and-mark
// or a query reads every entry in turn through the single read port; after the scan
// and a last step, the write-back step registers the result and writes a possible
// mark. A clear rewrites every entry, one per cycle, and then answers; an unused
// code goes straight to the hand-off step. req.ready is high only in the idle
// state, so a request occupies the block from its beat until its result is handed
// off. After reset the block sweeps every memory word to empty with req.ready low;
// the window resets to 20000. The result sits in an output register; a new request
// is taken while it waits, and a finished request holds in its last step until the
// register is free.
`default_nettype none

`include "assert_macros.svh"

module recent_key_dedup_table_core import rkd_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input wire logic clk,
	input wire logic arst_n,
	rkd_req_if.sink req,
	rkd_rsp_if.source rsp,
	input wire logic cfg_we,
	input wire logic [WIN_W-1:0] cfg_wdata
);

	localparam int AW = $clog2(ENTRIES);
	localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

	typedef enum logic [6:0] {
		S_INIT = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_SCAN = 7'b0000100,
		S_LAST = 7'b0001000,
		S_WRITE = 7'b0010000,
		S_CLEAR = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q;
	logic [AW-1:0] addr_q;
	logic [OP_W-1:0] op_q;
	logic [KEY_W-1:0] key_q;
	logic [TIME_W-1:0] now_q;
	logic [WIN_W-1:0] window_q;
	logic res_recent_q;
	logic res_marked_q;
	logic rsp_valid_q;
	logic was_recent_q;
	logic marked_q;

	logic req_fire;
	logic addr_last;
	logic out_free;
	logic mark_now;
	scan_ctrl_t scan_ctrl;
	logic scan_recent;
	logic [AW-1:0] scan_slot;

	logic mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t mem_wdata;
	logic mem_re;
	entry_t mem_rdata;

	assign req_fire = req.valid && req.ready;
	assign addr_last = (addr_q == LAST_IDX);
	assign out_free = !rsp_valid_q || rsp.ready;
	assign mark_now = (state_q == S_WRITE) && (op_q == OP_CHECK_MARK) && !scan_recent;

	assign req.ready = (state_q == S_IDLE);

	// Window register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q <= req.operation;
			key_q <= req.key;
			now_q <= req.now;
		end
	end

	// Sequencer: reset sweep, scan, write-back, clear sweep, hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			addr_q <= '0;
			res_recent_q <= 1'b0;
			res_marked_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					addr_q <= addr_q + 1'b1;
					if (addr_last) begin
						addr_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					addr_q <= '0;
					if (req_fire) begin
						res_recent_q <= 1'b0;
						res_marked_q <= 1'b0;
						unique case (req.operation) inside
							OP_CHECK_MARK, OP_QUERY: state_q <= S_SCAN;
							OP_CLEAR: state_q <= S_CLEAR;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					addr_q <= addr_q + 1'b1;
					if (addr_last) begin
						addr_q <= '0;
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					res_recent_q <= scan_recent;
					res_marked_q <= mark_now;
					state_q <= S_DONE;
				end
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_last) begin
						addr_q <= '0;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
					addr_q <= '0;
				end
			endcase
		end
	end

	// Output register toward the response channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			was_recent_q <= res_recent_q;
			marked_q <= res_marked_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.was_recent = was_recent_q;
	assign rsp.marked = marked_q;

	// Memory port control.
	always_comb begin
		mem_re = (state_q == S_SCAN);
		mem_we = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		if (state_q == S_INIT || state_q == S_CLEAR) begin
			mem_we = 1'b1;
		end else if (mark_now) begin
			mem_we = 1'b1;
			mem_waddr = scan_slot;
			mem_wdata.key = key_q;
			mem_wdata.stamp = now_q;
		end
	end

	always_comb begin
		scan_ctrl.start = req_fire;
		scan_ctrl.issue = mem_re;
	end

	rkd_mem #(
		.ENTRIES(ENTRIES)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(addr_q),
		.rdata(mem_rdata)
	);

	rkd_scan #(
		.ENTRIES(ENTRIES)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(scan_ctrl),
		.idx(addr_q),
		.rdata(mem_rdata),
		.key(key_q),
		.now(now_q),
		.window(window_q),
		.recent(scan_recent),
		.slot(scan_slot)
	);

	// The scan never reads while the table is being written.
	`RKD_ASSERT_NOW(a_no_rw_overlap, mem_we, !mem_re, "memory read and write overlap")
	// Only a check-and-mark of a key that is not recent writes during write-back.
	`RKD_ASSERT_NOW(a_mark_only, mem_we && state_q == S_WRITE,
		op_q == OP_CHECK_MARK && !scan_recent, "unexpected table write")
	// A response appears only after the sequencer hands one off.
	`RKD_ASSERT_NOW(a_rsp_source, $rose(rsp_valid_q), $past(state_q == S_DONE),
		"response without a finished request")
	// A result never claims both a recent hit and a mark.
	`RKD_ASSERT_NOW(a_rsp_exclusive, rsp.valid, !(rsp.was_recent && rsp.marked),
		"recent and marked both set")

endmodule

`default_nettype wire

// ===== sv/rkd_mem.sv =====
// Table memory: one write port and one registered read port.
`default_nettype none

module rkd_mem import rkd_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(ENTRIES)-1:0] waddr,
	input wire entry_t wdata,
	input wire logic re,
	input wire logic [$clog2(ENTRIES)-1:0] raddr,
	output entry_t rdata
);

	entry_t mem [ENTRIES];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, updated only while re is high.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/rkd_scan.sv =====
// Per-entry compare stage: recent test and victim slot selection.
`default_nettype none

module rkd_scan import rkd_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire scan_ctrl_t ctrl,
	input wire logic [$clog2(ENTRIES)-1:0] idx,
	input wire entry_t rdata,
	input wire logic [KEY_W-1:0] key,
	input wire logic [TIME_W-1:0] now,
	input wire logic [WIN_W-1:0] window,
	output logic recent,
	output logic [$clog2(ENTRIES)-1:0] slot
);

	localparam int AW = $clog2(ENTRIES);

	logic vld_s1;
	logic [AW-1:0] idx_s1;
	logic recent_q;
	logic found_q;
	logic [AW-1:0] found_idx_q;
	logic [AW-1:0] min_idx_q;
	logic [TIME_W-1:0] min_stamp_q;

	logic key_eq;
	logic stamp_nz;
	logic [TIME_W-1:0] age;
	logic hit;

	// Track which read data arrives from the memory this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctrl.issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx;
	end

	// Compare the entry against the request.
	always_comb begin
		key_eq = (rdata.key == key);
		stamp_nz = (rdata.stamp != '0);
		age = now - rdata.stamp;
		hit = key_eq && stamp_nz && (age < {{(TIME_W-WIN_W){1'b0}}, window});
	end

	// Accumulate the recent flag and the first matching or empty slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= 1'b0;
			found_q <= 1'b0;
		end else if (ctrl.start) begin
			recent_q <= 1'b0;
			found_q <= 1'b0;
		end else if (vld_s1) begin
			if (hit) begin
				recent_q <= 1'b1;
			end
			if (!found_q && (key_eq || !stamp_nz)) begin
				found_q <= 1'b1;
			end
		end
	end

	// Slot indexes and the oldest stamp seen before the first free slot.
	always_ff @(posedge clk) begin
		if (vld_s1 && !found_q) begin
			if (key_eq || !stamp_nz) begin
				found_idx_q <= idx_s1;
			end else if (idx_s1 == '0 || rdata.stamp < min_stamp_q) begin
				min_stamp_q <= rdata.stamp;
				min_idx_q <= idx_s1;
			end
		end
	end

	assign recent = recent_q;
	assign slot = found_q ? found_idx_q : min_idx_q;

endmodule

`default_nettype wire
